// ----- sv/tllhp_pkg.sv -----
// shared constants, types and helpers of the local-history branch predictor
package tllhp_pkg;

    // sizing
    localparam int ADDR_W        = 64;
    localparam int TABLE_ENTRIES = 256;
    localparam int WAYS          = 4;
    localparam int HISTORY_BITS  = 10;
    localparam int HIST_OUT_W    = 10;

    localparam int NUM_SETS = TABLE_ENTRIES / WAYS;
    // floor of log2 of the set count
    localparam int SET_BITS = $clog2(NUM_SETS + 1) - 1;
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = ADDR_W - SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int PT_SIZE  = 1 << HISTORY_BITS;

    // clearing pass covers both the pattern table and the history table sets
    localparam int CLR_COUNT = (PT_SIZE > NUM_SETS) ? PT_SIZE : NUM_SETS;
    localparam int CLR_W     = $clog2(CLR_COUNT);

    // pattern counter codes
    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] CNT_MIN       = 2'd0;
    localparam logic [CNT_W-1:0] CNT_INIT      = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TAKEN_MIN = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MAX       = 2'd3;

    // request codes
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    typedef logic [SET_W-1:0]        t_set;
    typedef logic [TAG_W-1:0]        t_tag;
    typedef logic [HISTORY_BITS-1:0] t_hist;
    typedef logic [RANK_W-1:0]       t_rank;
    typedef logic [WAY_W-1:0]        t_way_idx;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CLR_W-1:0]        t_clr_idx;

    // one way of a history table set
    typedef struct packed {
        logic  valid;
        t_tag  tag;
        t_hist hist;
        t_rank rank;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // set index from the low address bits
    function automatic t_set set_of(input logic [ADDR_W-1:0] addr);
        t_set s;
        if (SET_BITS == 0) begin
            s = '0;
        end else begin
            s = addr[SET_W-1:0];
        end
        return s;
    endfunction

    // tag from the address bits above the set index
    function automatic t_tag tag_of(input logic [ADDR_W-1:0] addr);
        return TAG_W'(addr >> SET_BITS);
    endfunction

endpackage

// ----- sv/two_level_local_history_predictor.sv -----
// two-level local-history branch predictor: history table, pattern table, pipeline
//
// Usage:
//   A request word (i_req_type, i_branch_addr, i_taken) is taken at a rising edge
//   where start is high and busy is low. Predict requests look the branch up
//   (allocating it on a miss) and answer from the pattern counter; update
//   requests also train the counter and shift the outcome into the history.
//   Each request gives exactly one result word on o_pred_taken, o_table_hit
//   and o_history_used, marked by o_valid for one cycle; the receiver cannot
//   hold it off.
//   Throughput: one request per cycle while busy is low; the three stages are
//   the set row read of the history table memory, the pattern counter memory
//   read, and the result register. Back-to-back requests to the same set or
//   the same counter are served by bypass registers.
//   Reset: a clearing pass writes every pattern counter to weakly not taken
//   and marks every history table set invalid, with busy high. No request is
//   taken during that pass.
module two_level_local_history_predictor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [tllhp_pkg::ADDR_W-1:0]      i_branch_addr,
    input  logic                              i_taken,
    output logic                              o_valid,
    output logic                              o_pred_taken,
    output logic                              o_table_hit,
    output logic [tllhp_pkg::HIST_OUT_W-1:0]  o_history_used
);
    import tllhp_pkg::*;

    // memories
    t_row row_mem [NUM_SETS];
    t_cnt pt_mem  [PT_SIZE];

    // clearing pass control
    t_state   r_state, n_state;
    t_clr_idx r_clr_idx, n_clr_idx;

    // stage 1 registers
    logic   r_s1_vld;
    t_set   r_s1_set;
    t_tag   r_s1_tag;
    logic   r_s1_upd;
    logic   r_s1_taken;
    t_row   r_row_rd;

    // row bypass
    logic   r_fw_vld;
    t_set   r_fw_set;
    t_row   r_fw_row;

    // stage 2 registers
    logic   r_s2_vld;
    t_hist  r_s2_h;
    logic   r_s2_hit;
    logic   r_s2_upd;
    logic   r_s2_taken;
    t_cnt   r_cnt_rd;

    // counter bypass
    logic   r_cw_vld;
    t_hist  r_cw_addr;
    t_cnt   r_cw_data;

    // result registers
    logic                   r_o_valid;
    logic                   r_o_pred;
    logic                   r_o_hit;
    logic [HIST_OUT_W-1:0]  r_o_hist;

    logic     accept;
    logic     s1_fw_sel;
    t_row     s1_row;
    logic [WAYS-1:0] s1_vbits;
    logic     s1_hit;
    t_way_idx s1_hit_way;
    t_way_idx s1_victim;
    logic     s1_found_inv;
    t_rank    s1_worst;
    t_way_idx s1_way;
    logic     s1_was_valid;
    t_rank    s1_old;
    t_hist    s1_h;
    t_hist    s1_new_hist;
    t_row     s1_new_row;

    t_cnt     s2_cnt;
    t_cnt     s2_new_cnt;
    logic     s2_wr;

    assign busy   = (r_state == ST_CLEAR);
    assign accept = start && !busy;

    // clearing pass state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    // clearing pass next state
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == t_clr_idx'(CLR_COUNT - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_clr_idx = '0;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        if (accept) begin
            r_s1_set   <= set_of(i_branch_addr);
            r_s1_tag   <= tag_of(i_branch_addr);
            r_s1_upd   <= (i_req_type == REQ_UPDATE);
            r_s1_taken <= i_taken;
        end
    end

    // history table row memory, cleared to invalid during the clearing pass
    always_ff @(posedge i_clk) begin
        r_row_rd <= row_mem[set_of(i_branch_addr)];
        if (r_state == ST_CLEAR) begin
            row_mem[t_set'(r_clr_idx)] <= '0;
        end else if (r_s1_vld) begin
            row_mem[r_s1_set] <= s1_new_row;
        end
    end

    // lookup, victim choice, rank aging and history shift
    always_comb begin
        s1_fw_sel    = r_fw_vld && (r_fw_set == r_s1_set);
        s1_row       = s1_fw_sel ? r_fw_row : r_row_rd;
        for (int w = 0; w < WAYS; w++) begin
            s1_vbits[w] = s1_row[w].valid;
        end
        s1_hit       = 1'b0;
        s1_hit_way   = '0;
        s1_victim    = '0;
        s1_found_inv = 1'b0;
        s1_worst     = '0;

        // first matching way
        for (int w = 0; w < WAYS; w++) begin
            if (!s1_hit && s1_vbits[w] && (s1_row[w].tag == r_s1_tag)) begin
                s1_hit     = 1'b1;
                s1_hit_way = t_way_idx'(w);
            end
        end

        // first invalid way, else first way of highest rank
        for (int w = 0; w < WAYS; w++) begin
            if (!s1_found_inv) begin
                if (!s1_vbits[w]) begin
                    s1_victim    = t_way_idx'(w);
                    s1_found_inv = 1'b1;
                end else if ((w == 0) || (s1_row[w].rank > s1_worst)) begin
                    s1_worst  = s1_row[w].rank;
                    s1_victim = t_way_idx'(w);
                end
            end
        end

        s1_way       = s1_hit ? s1_hit_way : s1_victim;
        s1_was_valid = s1_hit || !s1_found_inv;
        s1_old       = s1_row[s1_way].rank;
        s1_h         = s1_hit ? s1_row[s1_way].hist : '0;
        s1_new_hist  = r_s1_upd ? HISTORY_BITS'({s1_h, r_s1_taken}) : s1_h;

        // rewritten row
        s1_new_row = s1_row;
        for (int v = 0; v < WAYS; v++) begin
            if (t_way_idx'(v) == s1_way) begin
                s1_new_row[v].valid = 1'b1;
                s1_new_row[v].tag   = r_s1_tag;
                s1_new_row[v].hist  = s1_new_hist;
                s1_new_row[v].rank  = '0;
            end else if (s1_vbits[v] && (!s1_was_valid || (s1_row[v].rank < s1_old))) begin
                s1_new_row[v].rank = s1_row[v].rank + 1'b1;
            end
        end
    end

    // row bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= r_s1_vld;
        end
        r_fw_set <= r_s1_set;
        r_fw_row <= s1_new_row;
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_h     <= s1_h;
        r_s2_hit   <= s1_hit;
        r_s2_upd   <= r_s1_upd;
        r_s2_taken <= r_s1_taken;
    end

    // pattern counter read with bypass, saturating train
    always_comb begin
        s2_cnt = (r_cw_vld && (r_cw_addr == r_s2_h)) ? r_cw_data : r_cnt_rd;
        s2_new_cnt = s2_cnt;
        if (r_s2_taken) begin
            if (s2_cnt != CNT_MAX) begin
                s2_new_cnt = s2_cnt + 1'b1;
            end
        end else begin
            if (s2_cnt != CNT_MIN) begin
                s2_new_cnt = s2_cnt - 1'b1;
            end
        end
        s2_wr = r_s2_vld && r_s2_upd;
    end

    // pattern table memory
    always_ff @(posedge i_clk) begin
        r_cnt_rd <= pt_mem[s1_h];
        if (r_state == ST_CLEAR) begin
            pt_mem[t_hist'(r_clr_idx)] <= CNT_INIT;
        end else if (s2_wr) begin
            pt_mem[r_s2_h] <= s2_new_cnt;
        end
    end

    // counter bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw_vld <= 1'b0;
        end else begin
            r_cw_vld <= s2_wr;
        end
        r_cw_addr <= r_s2_h;
        r_cw_data <= s2_new_cnt;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_s2_vld;
        end
        r_o_pred <= (s2_cnt >= CNT_TAKEN_MIN);
        r_o_hit  <= r_s2_hit;
        r_o_hist <= HIST_OUT_W'(r_s2_h);
    end

    assign o_valid        = r_o_valid;
    assign o_pred_taken   = r_o_pred;
    assign o_table_hit    = r_o_hit;
    assign o_history_used = r_o_hist;

    // every accepted word gives a result on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("accepted word produced no result");

    // the pipeline is empty during the clearing pass
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !(r_s1_vld || r_s2_vld || r_o_valid))
        else $error("request in flight during clearing pass");

    // the way looked up is valid afterwards
    a_way_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |=> r_fw_row[$past(s1_way)].valid)
        else $error("looked-up way not marked valid");

    // a full set evicts the way of the oldest rank
    a_evict_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_hit && !s1_found_inv) |->
            (s1_row[s1_victim].rank == t_rank'(WAYS - 1)))
        else $error("eviction of a way that is not least recently used");

endmodule

// ----- bench/tb_two_level_local_history_predictor.sv -----
// self-checking testbench of the two-level local-history branch predictor
`timescale 1ns / 1ps

module tb_two_level_local_history_predictor;

    import tllhp_pkg::*;

    // one expected result word
    typedef struct packed {
        logic                  pred_taken;
        logic                  table_hit;
        logic [HIST_OUT_W-1:0] history_used;
    } t_branch_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic [ADDR_W-1:0]     i_branch_addr;
    logic                  i_taken;
    logic                  o_valid;
    logic                  o_pred_taken;
    logic                  o_table_hit;
    logic [HIST_OUT_W-1:0] o_history_used;

    // local copy of the predictor state
    t_tag  hist_tag   [TABLE_ENTRIES];
    t_hist hist_bits  [TABLE_ENTRIES];
    bit    hist_valid [TABLE_ENTRIES];
    int    hist_rank  [TABLE_ENTRIES];
    t_cnt  pattern_cnt[PT_SIZE];

    t_branch_outcome pending_outcomes[$];

    int idle_pct     = 0;
    int error_count  = 0;
    int words_sent   = 0;
    int words_seen   = 0;
    int hits_seen    = 0;
    int updates_sent = 0;

    two_level_local_history_predictor u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_branch_addr  (i_branch_addr),
        .i_taken        (i_taken),
        .o_valid        (o_valid),
        .o_pred_taken   (o_pred_taken),
        .o_table_hit    (o_table_hit),
        .o_history_used (o_history_used)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // make way w of the set at base the most recent one
    function automatic void make_most_recent(input int base, input int w, input bit was_valid);
        int old_rank;
        int v;
        old_rank = hist_rank[base + w];
        for (v = 0; v < WAYS; v++) begin
            if (v != w && hist_valid[base + v]) begin
                if (!was_valid || hist_rank[base + v] < old_rank) begin
                    hist_rank[base + v]++;
                end
            end
        end
        hist_rank[base + w] = 0;
    endfunction

    // look the branch up, allocate on a miss, train on update, return the result word
    function automatic t_branch_outcome predict_branch(input logic req,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic tk);
        int              base;
        int              entry;
        int              victim;
        int              worst;
        int              w;
        bit              hit;
        bit              found_free;
        t_tag            tag;
        t_hist           h;
        t_cnt            c;
        t_branch_outcome res;
        base       = int'(set_of(addr)) * WAYS;
        tag        = t_tag'(addr >> SET_BITS);
        hit        = 1'b0;
        found_free = 1'b0;
        entry      = -1;
        victim     = 0;
        worst      = 0;
        for (w = 0; w < WAYS; w++) begin
            if (entry < 0 && hist_valid[base + w] && hist_tag[base + w] == tag) begin
                entry = base + w;
                hit   = 1'b1;
                make_most_recent(base, w, 1'b1);
            end
        end
        // miss: first invalid way, else the oldest one
        if (!hit) begin
            for (w = 0; w < WAYS; w++) begin
                if (!found_free) begin
                    if (!hist_valid[base + w]) begin
                        victim     = w;
                        found_free = 1'b1;
                    end else if (w == 0 || hist_rank[base + w] > worst) begin
                        worst  = hist_rank[base + w];
                        victim = w;
                    end
                end
            end
            make_most_recent(base, victim, !found_free);
            entry             = base + victim;
            hist_tag[entry]   = tag;
            hist_bits[entry]  = '0;
            hist_valid[entry] = 1'b1;
        end
        h                = hist_bits[entry];
        c                = pattern_cnt[h];
        res.pred_taken   = (c >= CNT_TAKEN_MIN);
        res.table_hit    = hit;
        res.history_used = HIST_OUT_W'(h);
        // training
        if (req == REQ_UPDATE) begin
            if (tk && c != CNT_MAX) begin
                pattern_cnt[h] = c + 1'b1;
            end else if (!tk && c != CNT_MIN) begin
                pattern_cnt[h] = c - 1'b1;
            end
            hist_bits[entry] = t_hist'({h, tk});
        end
        return res;
    endfunction

    // send one request word; the sender idles each cycle at the set rate
    task automatic send_word(input logic req, input logic [ADDR_W-1:0] addr, input logic tk);
        @(negedge i_clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start         = 1'b1;
        i_req_type    = req;
        i_branch_addr = addr;
        i_taken       = tk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_outcomes.push_back(predict_branch(req, addr, tk));
        words_sent++;
        if (req == REQ_UPDATE) begin
            updates_sent++;
        end
    endtask

    // hold off until every expected word has come back
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // extremes of the address, hit and miss, predict ignoring taken, low saturation
    task automatic test_predict_corners();
        send_word(REQ_PREDICT, '1, 1'b1);
        send_word(REQ_PREDICT, '1, 1'b0);
        send_word(REQ_UPDATE, '0, 1'b0);
        send_word(REQ_UPDATE, '0, 1'b0);
        send_word(REQ_PREDICT, '0, 1'b1);
    endtask

    // fill the history, push it past its width, saturate the counter high
    task automatic test_counter_saturation();
        repeat (HISTORY_BITS + 3) send_word(REQ_UPDATE, '1, 1'b1);
    endtask

    // fill a set, touch a middle way, evict twice
    task automatic test_set_replacement();
        int i;
        for (i = 1; i <= WAYS + 1; i++) begin
            send_word(REQ_PREDICT, (ADDR_W'(i) << SET_BITS) | ADDR_W'(5), 1'b0);
            if (i == WAYS) begin
                send_word(REQ_UPDATE, (ADDR_W'(2) << SET_BITS) | ADDR_W'(5), 1'b1);
            end
        end
        send_word(REQ_PREDICT, (ADDR_W'(1) << SET_BITS) | ADDR_W'(5), 1'b0);
    endtask

    // hot branches crowded into a few sets, with some random addresses as noise
    task automatic test_random_traffic(input int n_words, input int gap_pct);
        logic [ADDR_W-1:0] hot_addr[20];
        bit                hot_bias[20];
        int                hot_set[4];
        logic [ADDR_W-1:0] addr;
        logic              req;
        logic              tk;
        int                i;
        int                k;
        idle_pct = gap_pct;
        for (i = 0; i < 4; i++) begin
            hot_set[i] = $urandom_range(NUM_SETS - 1);
        end
        for (i = 0; i < 20; i++) begin
            hot_addr[i] = ({$urandom, $urandom} / NUM_SETS) * NUM_SETS + hot_set[i % 4];
            hot_bias[i] = $urandom_range(1);
        end
        for (i = 0; i < n_words; i++) begin
            k   = $urandom_range(19);
            req = ($urandom_range(99) < 60) ? REQ_UPDATE : REQ_PREDICT;
            if ($urandom_range(99) < 85) begin
                addr = hot_addr[k];
                tk   = ($urandom_range(99) < 80) ? hot_bias[k] : !hot_bias[k];
            end else begin
                addr = {$urandom, $urandom};
                tk   = $urandom_range(1);
            end
            send_word(req, addr, tk);
        end
        drain_results();
        idle_pct = 0;
    endtask

    // result checker; the result side has no back-pressure
    always @(posedge i_clk) begin : check_results
        t_branch_outcome exp_word;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (o_table_hit) begin
                hits_seen++;
            end
            if (pending_outcomes.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                exp_word = pending_outcomes.pop_front();
                if (o_pred_taken !== exp_word.pred_taken) begin
                    $error("pred_taken: expected %0d, got %0d",
                           exp_word.pred_taken, o_pred_taken);
                    error_count++;
                end
                if (o_table_hit !== exp_word.table_hit) begin
                    $error("table_hit: expected %0d, got %0d",
                           exp_word.table_hit, o_table_hit);
                    error_count++;
                end
                if (o_history_used !== exp_word.history_used) begin
                    $error("history_used: expected 0x%0h, got 0x%0h",
                           exp_word.history_used, o_history_used);
                    error_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // main sequence
    initial begin : main_seq
        int i;
        int waited;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = REQ_PREDICT;
        i_branch_addr = '0;
        i_taken       = 1'b0;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            hist_tag[i]   = '0;
            hist_bits[i]  = '0;
            hist_valid[i] = 1'b0;
            hist_rank[i]  = 0;
        end
        for (i = 0; i < PT_SIZE; i++) begin
            pattern_cnt[i] = CNT_INIT;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // busy covers the pattern table clearing pass
        test_predict_corners();
        test_counter_saturation();
        test_set_replacement();
        drain_results();

        test_random_traffic(210, 0);
        test_random_traffic(210, 48);
        test_random_traffic(210, 31);

        // let the pipeline empty
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d result words never came", pending_outcomes.size());
            error_count++;
        end

        $display("sent %0d request words (%0d updates), checked %0d result words, %0d hits",
                 words_sent, updates_sent, words_seen, hits_seen);
        $display("covered address extremes, counter saturation, set fill and LRU eviction");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
